@@ rtl/pad_pkg.sv @@
// ----------------------------------------------------------------------------
// pad_pkg
// Shared types and constants for the phase-angle dimmer: field widths,
// request kinds, register indexes and the fixed-point rate scale.
// ----------------------------------------------------------------------------
package pad_pkg;

  // Field widths
  localparam int PCT_W    = 7;   // brightness percent
  localparam int LEVEL_W  = 8;   // raw requested level
  localparam int PHASE_W  = 8;   // phase counter and compare values
  localparam int RATE_W   = 21;  // timer rate register
  localparam int CH_W     = 3;   // channel field
  localparam int GATES_W  = 8;   // gate drive word
  localparam int IDX_W    = 2;   // config register index

  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [GATES_W-1:0] gates_t;
  typedef logic [IDX_W-1:0]   cfg_idx_t;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_ZERO_CROSS = 2'd1,
    KIND_SET_LEVEL  = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MIN_PERCENT = 2'd0,
    REG_MAX_PERCENT = 2'd1,
    REG_TIMER_RATE  = 2'd2
  } reg_index_t;

  // Register reset values
  localparam pct_t  MIN_RESET     = 7'd20;
  localparam pct_t  MAX_RESET     = 7'd95;
  localparam rate_t RATE_RESET    = 21'd19531;
  localparam pct_t  PENDING_RESET = MIN_RESET - 7'd1;
  localparam pct_t  FULL_PERCENT  = 7'd100;
  localparam pct_t  PCT_MAX       = 7'h7F;
  localparam phase_t PHASE_MAX    = 8'hFF;

  // Rate scale: floor(rate * RATE_RECIP / 2^RECIP_SHIFT) + 1, which sits above
  // rate * 2^SCALE_FRAC / RATE_DIVISOR by less than 1.01. Multiplying the dark
  // percent by it and dropping SCALE_FRAC bits gives the exact floor of
  // dark * rate / RATE_DIVISOR for dark <= 100, since the excess stays below
  // 1 / RATE_DIVISOR.
  localparam int RATE_DIVISOR = 10000;
  localparam int SCALE_FRAC   = 20;
  localparam int SCALE_W      = 28;
  localparam int RECIP_SHIFT  = 26;
  localparam int RECIP_W      = 33;

  typedef logic [SCALE_W-1:0] scale_t;

  // ceil(2^(SCALE_FRAC+RECIP_SHIFT) / RATE_DIVISOR)
  localparam logic [RECIP_W-1:0] RATE_RECIP =
    RECIP_W'(((64'd1 << (SCALE_FRAC + RECIP_SHIFT)) + 64'(RATE_DIVISOR - 1))
             / RATE_DIVISOR);
  localparam scale_t SCALE_RESET =
    SCALE_W'(((64'(RATE_RESET) * 64'(RATE_RECIP)) >> RECIP_SHIFT) + 64'd1);

endpackage

@@ rtl/pad_scale_div.sv @@
// ----------------------------------------------------------------------------
// pad_scale_div
// Turns a new timer rate into the fixed-point rate scale by a reciprocal
// multiply: rate capture, registered partial products, then sum and shift.
// ----------------------------------------------------------------------------
module pad_scale_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pad_pkg::rate_t  rate,
  output logic            busy,
  output pad_pkg::scale_t scale
);
  import pad_pkg::*;

  localparam int LO_W   = 17;
  localparam int HI_W   = RECIP_W - LO_W;
  localparam int PROD_W = RATE_W + RECIP_W;
  localparam logic [LO_W-1:0] RECIP_LO = RATE_RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RATE_RECIP[RECIP_W-1:LO_W];

  rate_t                  rate_q;
  logic [RATE_W+LO_W-1:0] part_lo;
  logic [RATE_W+HI_W-1:0] part_hi;
  logic [PROD_W-1:0]      prod;
  scale_t                 scale_next;
  logic                   sum_step;

  // Full product from the two partial products
  always_comb begin
    prod       = (PROD_W'(part_hi) << LO_W) + PROD_W'(part_lo);
    scale_next = prod[RECIP_SHIFT +: SCALE_W] + SCALE_W'(1);
  end

  // Control; the scale register changes only when the sum is ready
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sum_step <= 1'b0;
      scale    <= SCALE_RESET;
    end else if (start) begin
      busy     <= 1'b1;
      sum_step <= 1'b0;
    end else if (busy) begin
      if (sum_step) begin
        scale    <= scale_next;
        busy     <= 1'b0;
        sum_step <= 1'b0;
      end else begin
        sum_step <= 1'b1;
      end
    end
  end

  // Rate capture and partial products
  always_ff @(posedge clk) begin
    if (start) begin
      rate_q <= rate;
    end
    if (busy && !sum_step) begin
      part_lo <= (RATE_W+LO_W)'(rate_q) * (RATE_W+LO_W)'(RECIP_LO);
      part_hi <= (RATE_W+HI_W)'(rate_q) * (RATE_W+HI_W)'(RECIP_HI);
    end
  end

endmodule

@@ rtl/phase_angle_dimmer_core.sv @@
// ----------------------------------------------------------------------------
// phase_angle_dimmer_core
// Multi-channel triac phase-angle dimmer: timer ticks, mains zero crossings
// and set-level requests drive one gate bit per channel.
//
//   channel   handshake                  payload
//   --------  -------------------------  ------------------------------
//   request   item_valid / item_stall    kind, channel, level
//   result    result_valid / result_stall gates, ignored
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One request per cycle unless item_stall is high; each passes an input and a
// result register before it is presented. A timer rate write starts a
// reciprocal multiply that refreshes the rate scale; request stall and
// cfg_ready hold it off meanwhile. Reset clears the channel state but loads
// pending levels with PENDING_RESET; the request side is open right after reset.
// A stalled result keeps its register; one more request waits in the input
// register, then item_stall rises.
// ----------------------------------------------------------------------------
module phase_angle_dimmer_core #(
  parameter int CHANNELS = 3
) (
  input  logic                clk,
  input  logic                rst,
  // requests
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          kind,
  input  pad_pkg::chan_t      channel,
  input  pad_pkg::level_t     level,
  // results
  output logic                result_valid,
  input  logic                result_stall,
  output pad_pkg::gates_t     gates,
  output logic                ignored,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pad_pkg::cfg_idx_t   cfg_index,
  input  pad_pkg::rate_t      cfg_data
);
  import pad_pkg::*;

  // Dark percent times rate scale, saturated to the counter range
  function automatic phase_t compare_of(pct_t lvl, scale_t scl);
    pct_t                              dark;
    logic [PCT_W+SCALE_W-1:0]          prod;
    logic [PCT_W+SCALE_W-SCALE_FRAC-1:0] whole;
    dark  = (lvl < FULL_PERCENT) ? FULL_PERCENT - lvl : '0;
    prod  = (PCT_W+SCALE_W)'(dark) * (PCT_W+SCALE_W)'(scl);
    whole = prod[PCT_W+SCALE_W-1:SCALE_FRAC];
    if (whole[PCT_W+SCALE_W-SCALE_FRAC-1:PHASE_W] != '0) begin
      compare_of = PHASE_MAX;
    end else begin
      compare_of = whole[PHASE_W-1:0];
    end
  endfunction

  // Configuration registers
  pct_t   min_percent;
  pct_t   max_percent;
  scale_t scale;
  logic   div_busy;
  logic   cfg_write;
  logic   rate_write;

  // Input register
  logic       hold_valid;
  logic [1:0] hold_kind;
  chan_t      hold_channel;
  level_t     hold_level;
  logic       fire;
  logic       accept;

  // Channel state
  phase_t              phase_count;
  logic [CHANNELS-1:0] armed;
  logic [CHANNELS-1:0] gate_bits;
  pct_t                active_level  [CHANNELS];
  pct_t                pending_level [CHANNELS];
  phase_t              compare_value [CHANNELS];

  phase_t              phase_count_next;
  logic [CHANNELS-1:0] armed_next;
  logic [CHANNELS-1:0] gate_bits_next;
  pct_t                active_level_next  [CHANNELS];
  pct_t                pending_level_next [CHANNELS];
  phase_t              compare_value_next [CHANNELS];
  logic                ignored_next;

  pct_t                clamped;
  pct_t                max_up;

  // Handshakes
  assign cfg_ready  = ~div_busy;
  assign cfg_write  = cfg_valid & cfg_ready;
  assign rate_write = cfg_write & (cfg_index == REG_TIMER_RATE);
  assign fire       = hold_valid & (~result_valid | ~result_stall);
  assign item_stall = div_busy | (hold_valid & ~fire);
  assign accept     = item_valid & ~item_stall;

  // Rate scale from the timer rate
  pad_scale_div u_scale_div (
    .clk   (clk),
    .rst   (rst),
    .start (rate_write),
    .rate  (cfg_data),
    .busy  (div_busy),
    .scale (scale)
  );

  // Percent limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_percent <= MIN_RESET;
      max_percent <= MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_PERCENT: min_percent <= cfg_data[PCT_W-1:0];
        REG_MAX_PERCENT: max_percent <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_kind    <= kind;
      hold_channel <= channel;
      hold_level   <= level;
    end
  end

  // Set-level clamp: above max goes to max+1, below min to min-1
  always_comb begin
    max_up  = (max_percent == PCT_MAX) ? PCT_MAX : max_percent + 7'd1;
    clamped = hold_level[PCT_W-1:0];
    if (hold_level > LEVEL_W'(max_percent)) begin
      clamped = max_up;
    end
    if (hold_level < LEVEL_W'(min_percent)) begin
      clamped = min_percent - 7'd1;
    end
  end

  // Next channel state for the request in the input register
  always_comb begin
    phase_count_next = phase_count;
    armed_next       = armed;
    gate_bits_next   = gate_bits;
    ignored_next     = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      active_level_next[i]  = active_level[i];
      pending_level_next[i] = pending_level[i];
      compare_value_next[i] = compare_value[i];
    end
    case (hold_kind)
      KIND_TICK: begin
        phase_count_next = phase_count + 8'd1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (compare_value[i] == phase_count_next) begin
            if (armed[i]) begin
              armed_next[i] = 1'b0;
              if (active_level[i] > min_percent) begin
                gate_bits_next[i] = 1'b1;
              end
            end
            if (active_level[i] != pending_level[i]) begin
              active_level_next[i]  = pending_level[i];
              compare_value_next[i] = compare_of(pending_level[i], scale);
            end
          end
        end
      end
      KIND_ZERO_CROSS: begin
        if (armed != '0) begin
          ignored_next = 1'b1;
        end else begin
          armed_next       = '1;
          phase_count_next = '0;
          for (int i = 0; i < CHANNELS; i++) begin
            if (active_level[i] < max_percent) begin
              gate_bits_next[i] = 1'b0;
            end
          end
        end
      end
      KIND_SET_LEVEL: begin
        if ((CH_W+1)'(hold_channel) >= (CH_W+1)'(CHANNELS)) begin
          ignored_next = 1'b1;
        end else begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (hold_channel == CH_W'(i)) begin
              pending_level_next[i] = clamped;
            end
          end
        end
      end
      default: begin
        ignored_next = 1'b1;
      end
    endcase
  end

  // Channel state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      armed       <= '0;
      gate_bits   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        active_level[i]  <= '0;
        pending_level[i] <= PENDING_RESET;
        compare_value[i] <= '0;
      end
    end else if (fire) begin
      phase_count <= phase_count_next;
      armed       <= armed_next;
      gate_bits   <= gate_bits_next;
      for (int i = 0; i < CHANNELS; i++) begin
        active_level[i]  <= active_level_next[i];
        pending_level[i] <= pending_level_next[i];
        compare_value[i] <= compare_value_next[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      gates   <= GATES_W'(gate_bits_next);
      ignored <= ignored_next;
    end
  end

  // A zero crossing taken with nothing armed restarts the half cycle
  ap_zero_cross: assert property (@(posedge clk) disable iff (rst)
    (fire && hold_kind == KIND_ZERO_CROSS && armed == '0)
      |=> (phase_count == '0 && armed == '1))
    else $error("zero crossing did not rearm channels");

  // Gates only turn on at a tick
  ap_gate_rise: assert property (@(posedge clk) disable iff (rst)
    (fire && hold_kind != KIND_TICK) |=> ((gate_bits & ~$past(gate_bits)) == '0))
    else $error("gate rose outside a tick");

  // The result shows the gate state left by its request
  ap_result_gates: assert property (@(posedge clk) disable iff (rst)
    fire |=> (result_valid && gates == GATES_W'(gate_bits)))
    else $error("result gates differ from channel state");

  // A rate write holds off requests while the scale is rebuilt
  ap_rate_busy: assert property (@(posedge clk) disable iff (rst)
    rate_write |=> (div_busy && item_stall && !cfg_ready))
    else $error("rate write did not start the scale divider");

endmodule
